/* rtl/dlfkh_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and the FNV-1a absorb step for the dual lane key hash.
// No dependencies.
package dlfkh_pkg;

    localparam int          LANE_W       = 64;
    localparam int          BYTE_W       = 8;
    localparam int          ABI_W        = 32;
    localparam int          STEP_W       = 3;

    // FNV 64-bit prime = 2^40 + 0x1B3
    localparam int          PRIME_SHIFT  = 40;
    localparam logic [8:0]  PRIME_LOW    = 9'h1B3;

    localparam logic [LANE_W-1:0] LOW_OFFSET  = 64'd14695981039346656037;
    localparam logic [LANE_W-1:0] HIGH_OFFSET = 64'd7809847782465536322;

    localparam logic [BYTE_W-1:0] PREFIX_MASK = 8'hA5;
    localparam logic [BYTE_W-1:0] SUFFIX_MASK = 8'h5A;

    localparam logic [STEP_W-1:0] PREFIX_LAST = 3'd3;
    localparam logic [STEP_W-1:0] SUFFIX_LAST = 3'd7;

    function automatic logic [LANE_W-1:0] fnv_absorb(
        input logic [LANE_W-1:0] lane,
        input logic [BYTE_W-1:0] b
    );
        logic [LANE_W-1:0] x;
        x = lane ^ {{(LANE_W-BYTE_W){1'b0}}, b};
        return (x << PRIME_SHIFT) + x * {{(LANE_W-9){1'b0}}, PRIME_LOW};
    endfunction

endpackage

/* rtl/dual_lane_fnv1a_key_hash.sv */
`timescale 1ns / 1ps
// Dual lane FNV-1a 128-bit key hash over a byte stream.
// Depends on dlfkh_pkg (constants, absorb step).
//
// Channel  Dir  Signals                     Content
// s        in   s_tvalid/s_tready/s_tdata   data_byte; s_tuser = has_byte; s_tlast = end_of_message
// m        out  m_tvalid/m_tready/m_tdata   key_low [63:0], key_high [127:64]
// cfg      in   cfg_we/cfg_wdata            abi_version
//
// One absorb unit updates both lanes in each prefix, byte and suffix step under a small sequencer.
// Byte item: accept, then absorb. The first item of a message first absorbs the abi_version bytes as a prefix.
// The end item of a message with bytes absorbs the byte count as a length suffix, then loads the output register.
// s_tready is low while an item is in work or the result waits for the output register.
// Reset: lanes at their offsets, count zero, no message open, abi_version zero.
module dual_lane_fnv1a_key_hash (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] key_low, [127:64] key_high
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_BYTE,
        ST_SUFFIX,
        ST_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [dlfkh_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [dlfkh_pkg::LANE_W-1:0]        low_reg, low_next;
    logic [dlfkh_pkg::LANE_W-1:0]        high_reg, high_next;
    logic [dlfkh_pkg::LANE_W-1:0]        count_reg, count_next;
    logic                                in_msg_reg, in_msg_next;
    logic [dlfkh_pkg::BYTE_W-1:0]        data_reg, data_next;
    logic                                has_reg, has_next;
    logic                                last_reg, last_next;
    logic [dlfkh_pkg::ABI_W-1:0]         abi_reg, abi_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [dlfkh_pkg::LANE_W-1:0]        key_low_reg, key_low_next;
    logic [dlfkh_pkg::LANE_W-1:0]        key_high_reg, key_high_next;

    logic [dlfkh_pkg::BYTE_W-1:0]        unit_low_b;
    logic [dlfkh_pkg::BYTE_W-1:0]        unit_high_b;
    logic [dlfkh_pkg::LANE_W-1:0]        unit_low;
    logic [dlfkh_pkg::LANE_W-1:0]        unit_high;
    logic [dlfkh_pkg::BYTE_W-1:0]        prefix_b;
    logic [dlfkh_pkg::BYTE_W-1:0]        suffix_b;
    logic                                s_accept;

    function automatic state_t route(
        input logic has,
        input logic last,
        input logic cnt_zero
    );
        state_t r;
        if (has)
            r = ST_BYTE;
        else if (last && cnt_zero)
            r = ST_EMIT;
        else if (last)
            r = ST_SUFFIX;
        else
            r = ST_IDLE;
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {key_high_reg, key_low_reg};

    assign prefix_b = abi_reg[step_reg[1:0]*dlfkh_pkg::BYTE_W +: dlfkh_pkg::BYTE_W];
    assign suffix_b = count_reg[step_reg*dlfkh_pkg::BYTE_W +: dlfkh_pkg::BYTE_W];

    // shared absorb unit: byte selection
    always_comb
    begin
        case (state_reg)
            ST_PREFIX:
            begin
                unit_low_b  = prefix_b;
                unit_high_b = prefix_b ^ dlfkh_pkg::PREFIX_MASK;
            end
            ST_SUFFIX:
            begin
                unit_low_b  = suffix_b;
                unit_high_b = suffix_b ^ dlfkh_pkg::SUFFIX_MASK;
            end
            default:
            begin
                unit_low_b  = data_reg;
                unit_high_b = {data_reg[6:0], data_reg[7]};
            end
        endcase
    end

    assign unit_low  = dlfkh_pkg::fnv_absorb(low_reg, unit_low_b);
    assign unit_high = dlfkh_pkg::fnv_absorb(high_reg, unit_high_b);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        count_next    = count_reg;
        in_msg_next   = in_msg_reg;
        data_next     = data_reg;
        has_next      = has_reg;
        last_next     = last_reg;
        abi_next      = cfg_we ? cfg_wdata : abi_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    data_next   = s_tdata;
                    has_next    = s_tuser;
                    last_next   = s_tlast;
                    in_msg_next = 1'b1;
                    step_next   = '0;
                    if (!in_msg_reg)
                        state_next = ST_PREFIX;
                    else
                        state_next = route(s_tuser, s_tlast, count_reg == '0);
                end
            end
            ST_PREFIX:
            begin
                low_next  = unit_low;
                high_next = unit_high;
                step_next = step_reg + 1'b1;
                if (step_reg == dlfkh_pkg::PREFIX_LAST)
                begin
                    step_next  = '0;
                    state_next = route(has_reg, last_reg, count_reg == '0);
                end
            end
            ST_BYTE:
            begin
                low_next   = unit_low;
                high_next  = unit_high;
                count_next = count_reg + 1'b1;
                step_next  = '0;
                state_next = route(1'b0, last_reg, count_next == '0);
            end
            ST_SUFFIX:
            begin
                low_next  = unit_low;
                high_next = unit_high;
                step_next = step_reg + 1'b1;
                if (step_reg == dlfkh_pkg::SUFFIX_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    key_low_next  = (count_reg == '0) ? '0 : low_reg;
                    key_high_next = (count_reg == '0) ? '0 : high_reg;
                    low_next      = dlfkh_pkg::LOW_OFFSET;
                    high_next     = dlfkh_pkg::HIGH_OFFSET;
                    count_next    = '0;
                    in_msg_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            low_reg      <= dlfkh_pkg::LOW_OFFSET;
            high_reg     <= dlfkh_pkg::HIGH_OFFSET;
            count_reg    <= '0;
            in_msg_reg   <= 1'b0;
            data_reg     <= '0;
            has_reg      <= 1'b0;
            last_reg     <= 1'b0;
            abi_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            count_reg    <= count_next;
            in_msg_reg   <= in_msg_next;
            data_reg     <= data_next;
            has_reg      <= has_next;
            last_reg     <= last_next;
            abi_reg      <= abi_next;
            m_tvalid_reg <= m_tvalid_next;
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

`ifndef SYNTHESIS
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    a_suffix_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUFFIX) |-> (count_reg != '0))
        else $error("length suffix on empty message");

    a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BYTE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("byte count not advanced");

    a_idle_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !in_msg_reg) |->
            (low_reg == dlfkh_pkg::LOW_OFFSET && high_reg == dlfkh_pkg::HIGH_OFFSET))
        else $error("lanes not at offsets between messages");
`endif

endmodule
